// ===== hdl/u2g_pkg.sv =====
package u2g_pkg;

    localparam int unsigned CpW    = 21;
    localparam int unsigned GlyphW = 8;

    localparam logic [CpW-1:0]    CpQmark    = 21'h00003F;
    localparam logic [CpW-1:0]    CpAsciiLo  = 21'h000020;
    localparam logic [CpW-1:0]    CpAsciiHi  = 21'h00007E;
    localparam logic [CpW-1:0]    CpIo       = 21'h000401;
    localparam logic [CpW-1:0]    CpCyrLo    = 21'h000410;
    localparam logic [CpW-1:0]    CpCyrHi    = 21'h00044F;
    localparam logic [CpW-1:0]    CpYo       = 21'h000451;
    localparam logic [GlyphW-1:0] GlyphIo    = 8'd95;
    localparam logic [GlyphW-1:0] GlyphCyrLo = 8'd96;
    localparam logic [GlyphW-1:0] GlyphYo    = 8'd160;
    localparam logic [GlyphW-1:0] GlyphPunct = 8'd161;
    localparam logic [GlyphW-1:0] GlyphNone  = 8'd0;

    typedef struct packed {
        logic              any;
        logic [1:0]        flush_cnt;
        logic              has_tail;
        logic              tail_bad;
        logic [CpW-1:0]    tail_cp;
        logic [GlyphW-1:0] tail_glyph;
    } t_job;

    function automatic logic [GlyphW-1:0] glyph_of(input logic [CpW-1:0] cp);
        logic [CpW-1:0] d;
        logic [GlyphW-1:0] g;
        g = GlyphNone;
        d = '0;
        if (cp inside {[CpAsciiLo:CpAsciiHi]}) begin
            d = cp - CpAsciiLo;
            g = d[GlyphW-1:0];
        end else if (cp == CpIo) begin
            g = GlyphIo;
        end else if (cp inside {[CpCyrLo:CpCyrHi]}) begin
            d = cp - CpCyrLo;
            g = GlyphCyrLo + d[GlyphW-1:0];
        end else if (cp == CpYo) begin
            g = GlyphYo;
        end else begin
            case (cp)
                21'h0000AB: g = GlyphPunct;
                21'h0000BB: g = GlyphPunct + 8'd1;
                21'h002013: g = GlyphPunct + 8'd2;
                21'h002014: g = GlyphPunct + 8'd3;
                21'h002018: g = GlyphPunct + 8'd4;
                21'h002019: g = GlyphPunct + 8'd5;
                21'h00201C: g = GlyphPunct + 8'd6;
                21'h00201D: g = GlyphPunct + 8'd7;
                21'h002026: g = GlyphPunct + 8'd8;
                default:    g = GlyphNone;
            endcase
        end
        return g;
    endfunction

endpackage

// ===== hdl/u2g_decode.sv =====
module u2g_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_byte,
    output u2g_pkg::t_job o_job
);
    import u2g_pkg::*;

    logic [CpW-1:0] r_partial, n_partial;
    logic [1:0]     r_expected, n_expected;
    logic [1:0]     r_held, n_held;
    logic [CpW-1:0] joined;
    logic [CpW-1:0] tail_cp;
    t_job           job;

    assign joined = {r_partial[CpW-7:0], i_byte[5:0]};

    always_comb begin
        n_partial  = r_partial;
        n_expected = r_expected;
        n_held     = r_held;
        tail_cp    = CpQmark;
        job        = '0;
        if (r_expected != 2'd0 && i_byte[7:6] == 2'b10) begin
            if (r_expected == 2'd1) begin
                tail_cp      = joined;
                job.has_tail = 1'b1;
                n_partial    = '0;
                n_expected   = 2'd0;
                n_held       = 2'd0;
            end else begin
                n_partial  = joined;
                n_expected = r_expected - 2'd1;
                n_held     = r_held + 2'd1;
            end
        end else begin
            if (r_expected != 2'd0) begin
                job.flush_cnt = r_held;
            end
            n_partial  = '0;
            n_expected = 2'd0;
            n_held     = 2'd0;
            if (i_byte == 8'd0) begin
                job.has_tail = 1'b0;
            end else if (i_byte[7] == 1'b0) begin
                tail_cp      = {13'd0, i_byte};
                job.has_tail = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_partial  = {16'd0, i_byte[4:0]};
                n_expected = 2'd1;
                n_held     = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_partial  = {17'd0, i_byte[3:0]};
                n_expected = 2'd2;
                n_held     = 2'd1;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_partial  = {18'd0, i_byte[2:0]};
                n_expected = 2'd3;
                n_held     = 2'd1;
            end else begin
                job.has_tail = 1'b1;
                job.tail_bad = 1'b1;
            end
        end
        job.tail_cp    = tail_cp;
        job.tail_glyph = glyph_of(tail_cp);
        job.any        = job.has_tail || (job.flush_cnt != 2'd0);
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_expected <= 2'd0;
            r_held     <= 2'd0;
        end else if (i_accept) begin
            r_partial  <= n_partial;
            r_expected <= n_expected;
            r_held     <= n_held;
        end
    end

endmodule

// ===== hdl/u2g_out_seq.sv =====
module u2g_out_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  u2g_pkg::t_job            i_job,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [u2g_pkg::CpW-1:0]    o_codepoint,
    output logic [u2g_pkg::GlyphW-1:0] o_glyph_index,
    output logic                     o_malformed,
    output logic                     o_last
);
    import u2g_pkg::*;

    logic              r_valid, n_valid;
    logic [1:0]        r_flush, n_flush;
    logic              r_tail, n_tail;
    logic              r_bad;
    logic [CpW-1:0]    r_cp;
    logic [GlyphW-1:0] r_glyph;
    logic              take;
    logic              is_last;

    assign is_last    = (r_flush == 2'd0) || (r_flush == 2'd1 && !r_tail);
    assign take       = r_valid && i_ready;
    assign o_can_load = !r_valid || (i_ready && is_last);

    always_comb begin
        n_valid = r_valid;
        n_flush = r_flush;
        n_tail  = r_tail;
        if (i_load) begin
            n_valid = i_job.any;
            n_flush = i_job.flush_cnt;
            n_tail  = i_job.has_tail;
        end else if (take) begin
            if (is_last) begin
                n_valid = 1'b0;
                n_flush = 2'd0;
                n_tail  = 1'b0;
            end else begin
                n_flush = r_flush - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_flush <= 2'd0;
            r_tail  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_flush <= n_flush;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bad   <= i_job.tail_bad;
            r_cp    <= i_job.tail_cp;
            r_glyph <= i_job.tail_glyph;
        end
    end

    assign o_valid       = r_valid;
    assign o_codepoint   = (r_flush != 2'd0) ? CpQmark : r_cp;
    assign o_glyph_index = (r_flush != 2'd0) ? glyph_of(CpQmark) : r_glyph;
    assign o_malformed   = (r_flush != 2'd0) ? 1'b1 : r_bad;
    assign o_last        = is_last;

`ifndef ASSERT_OFF
    a_flush_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flush != 2'd0) |-> r_valid)
        else $error("pending flush count without a valid item");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_flush) && $stable(r_tail)))
        else $error("result sequence moved while stalled");
    a_no_load_midway: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_valid) |-> (take && is_last))
        else $error("new item loaded before the previous one finished");
    a_valid_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_tail || r_flush != 2'd0))
        else $error("valid result with nothing to emit");
`endif

endmodule

// ===== hdl/utf8_to_glyph_index_top.sv =====
// Channel | Valid      | Ready       | Payload
// in      | i_in_valid | o_in_ready  | i_in_byte
// out     | o_out_valid| i_out_ready | o_codepoint, o_glyph_index, o_malformed, o_last
//
// One byte is taken per cycle while the output keeps up; a byte that yields N
// results (0..4) holds the input until the sequencer has emitted them in order.
// A byte's first result is registered and shows in the cycle after its accept.
// i_rst_n is synchronous, active low, and clears any pending sequence.
// Output stall holds the current result; the next byte is taken in the same
// cycle that the final result of the previous one is taken.
module utf8_to_glyph_index_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_in_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [u2g_pkg::CpW-1:0]    o_codepoint,
    output logic [u2g_pkg::GlyphW-1:0] o_glyph_index,
    output logic                       o_malformed,
    output logic                       o_last
);
    import u2g_pkg::*;

    t_job job;
    logic can_load;
    logic accept;

    assign accept     = i_in_valid && can_load;
    assign o_in_ready = can_load;

    u2g_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .o_job    (job)
    );

    u2g_out_seq u_out_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_job         (job),
        .o_can_load    (can_load),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_codepoint   (o_codepoint),
        .o_glyph_index (o_glyph_index),
        .o_malformed   (o_malformed),
        .o_last        (o_last)
    );

endmodule
